@@ rtl/sdoc_pkg.sv @@
// ---------------------------------------------------------------------------
// sdoc_pkg: shared types and constants of the expedited SDO client
// Function codes, status codes, protocol constants and the records passed
// between the decode front, the command queue and the transfer engine.
// ---------------------------------------------------------------------------
package sdoc_pkg;

  localparam logic [1:0] FUNC_UPLOAD   = 2'd0;
  localparam logic [1:0] FUNC_DOWNLOAD = 2'd1;
  localparam logic [1:0] FUNC_RX_FRAME = 2'd2;
  localparam logic [1:0] FUNC_TICK     = 2'd3;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_ABORT      = 3'd1;
  localparam logic [2:0] STATUS_UNEXPECTED = 3'd2;
  localparam logic [2:0] STATUS_SEGMENTED  = 3'd3;
  localparam logic [2:0] STATUS_TIMEOUT    = 3'd4;
  localparam logic [2:0] STATUS_BAD_LEN    = 3'd5;
  localparam logic [2:0] STATUS_BUSY       = 3'd6;

  localparam logic [10:0] SDO_TX_BASE = 11'h600;
  localparam logic [10:0] SDO_RX_BASE = 11'h580;
  localparam logic [3:0]  FRAME_DLC   = 4'd8;

  localparam logic [7:0] CS_UPLOAD_REQ   = 8'h40;
  localparam logic [7:0] CS_DOWNLOAD_REQ = 8'h23;
  localparam logic [7:0] CS_ABORT        = 8'h80;
  localparam logic [7:0] CS_TOP_MASK     = 8'hE0;
  localparam logic [7:0] CS_DOWNLOAD_RSP = 8'h60;
  localparam logic [7:0] CS_UPLOAD_RSP   = 8'h40;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam int          QUEUE_DEPTH   = 2;

  // decoded item as it waits in the queue
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  node;
    logic [63:0] frame;     // request frame payload, or the received payload
    logic        bad_len;
    logic [10:0] rx_id;
    logic        dlc_ok;
    logic [2:0]  wr_status; // parse result if the pending transfer is a download
    logic [2:0]  rd_status; // parse result if the pending transfer is an upload
    logic [31:0] rd_data;
    logic [2:0]  rd_len;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] tx_can_id;
    logic [3:0]  tx_dlc;
    logic [63:0] tx_data;
    logic [2:0]  status;
    logic [31:0] abort_code;
    logic [31:0] read_data;
    logic [2:0]  read_len;
  } res_t;

endpackage

@@ rtl/canopen_sdo_expedited_client.sv @@
// ---------------------------------------------------------------------------
// canopen_sdo_expedited_client: CANopen expedited SDO client
// Turns upload/download requests into SDO request frames, matches server
// responses, reports completions and times out stalled transfers.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: an upload
//   or download request, a received CAN frame, or a timer tick (func).
//   Output channel (out_valid/out_ready) carries zero or one result per item:
//   a frame to transmit (kind 0) or a transfer completion (kind 1).
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes timeout_ticks; write
//   it only while no item is in flight. cfg_ready is always high.
// Flow:
//   An accepted item lands in the command queue; the engine takes it from the
//   queue and registers its result in the output register. One item per
//   cycle is sustained while out_ready is high.
// Reset: timeout_ticks returns to 1000, no transfer is pending, the queue and
//   the output register are empty.
// Stall: while out_ready is low the engine holds its result; the queue keeps
//   accepting until its QUEUE_DEPTH entries are full, then in_ready drops.
// ---------------------------------------------------------------------------
module canopen_sdo_expedited_client #(
  parameter int QUEUE_DEPTH = sdoc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [6:0]  node_id,
  input  logic [15:0] od_index,
  input  logic [7:0]  od_subindex,
  input  logic [31:0] write_data,
  input  logic [3:0]  write_len,
  input  logic [10:0] rx_can_id,
  input  logic [3:0]  rx_dlc,
  input  logic [63:0] rx_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [10:0] tx_can_id,
  output logic [3:0]  tx_dlc,
  output logic [63:0] tx_data,
  output logic [2:0]  status,
  output logic [31:0] abort_code,
  output logic [31:0] read_data,
  output logic [2:0]  read_len
);

  logic [15:0]    timeout_ticks;
  sdoc_pkg::cmd_t front_cmd;
  sdoc_pkg::cmd_t queue_cmd;
  logic           queue_valid;
  logic           queue_ready;
  sdoc_pkg::res_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= sdoc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  sdoc_front u_front (
    .func        (func),
    .node_id     (node_id),
    .od_index    (od_index),
    .od_subindex (od_subindex),
    .write_data  (write_data),
    .write_len   (write_len),
    .rx_can_id   (rx_can_id),
    .rx_dlc      (rx_dlc),
    .rx_data     (rx_data),
    .cmd         (front_cmd)
  );

  sdoc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  sdoc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .cmd_valid     (queue_valid),
    .cmd_ready     (queue_ready),
    .cmd           (queue_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result        (result)
  );

  assign kind       = result.kind;
  assign tx_can_id  = result.tx_can_id;
  assign tx_dlc     = result.tx_dlc;
  assign tx_data    = result.tx_data;
  assign status     = result.status;
  assign abort_code = result.abort_code;
  assign read_data  = result.read_data;
  assign read_len   = result.read_len;

endmodule

@@ rtl/sdoc_front.sv @@
// ---------------------------------------------------------------------------
// sdoc_front: item decode
// Builds request frames and parses received frames ahead of the transfer
// state, so the engine only has to pick results against its pending state.
// ---------------------------------------------------------------------------
module sdoc_front (
  input  logic [1:0]     func,
  input  logic [6:0]     node_id,
  input  logic [15:0]    od_index,
  input  logic [7:0]     od_subindex,
  input  logic [31:0]    write_data,
  input  logic [3:0]     write_len,
  input  logic [10:0]    rx_can_id,
  input  logic [3:0]     rx_dlc,
  input  logic [63:0]    rx_data,
  output sdoc_pkg::cmd_t cmd
);

  logic [63:0] addr_bytes;
  logic [31:0] wr_masked;
  logic [1:0]  wr_spare;
  logic [7:0]  wr_cs;
  logic [7:0]  b0;
  logic [31:0] hi;
  logic        is_abort;
  logic [2:0]  up_len;
  logic [31:0] up_masked;

  assign addr_bytes = {32'd0, od_subindex, od_index, 8'd0};
  assign wr_spare   = 2'(3'd4 - write_len[2:0]);
  assign wr_cs      = sdoc_pkg::CS_DOWNLOAD_REQ | {4'd0, wr_spare, 2'd0};

  always_comb begin
    unique case (write_len)
      4'd1:    wr_masked = {24'd0, write_data[7:0]};
      4'd2:    wr_masked = {16'd0, write_data[15:0]};
      4'd3:    wr_masked = {8'd0, write_data[23:0]};
      default: wr_masked = write_data;
    endcase
  end

  assign b0       = rx_data[7:0];
  assign hi       = rx_data[63:32];
  assign is_abort = (b0 == sdoc_pkg::CS_ABORT);
  // size indicated: four minus the unused byte count, otherwise four
  assign up_len   = b0[0] ? (3'd4 - {1'b0, b0[3:2]}) : 3'd4;

  always_comb begin
    unique case (up_len)
      3'd1:    up_masked = {24'd0, hi[7:0]};
      3'd2:    up_masked = {16'd0, hi[15:0]};
      3'd3:    up_masked = {8'd0, hi[23:0]};
      default: up_masked = hi;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = func;
    cmd.node    = node_id;
    cmd.bad_len = (write_len < 4'd1) || (write_len > 4'd4);
    cmd.rx_id   = rx_can_id;
    cmd.dlc_ok  = (rx_dlc >= sdoc_pkg::FRAME_DLC);
    cmd.rd_data = up_masked;
    cmd.rd_len  = up_len;

    priority if (is_abort) begin
      cmd.wr_status = sdoc_pkg::STATUS_ABORT;
      cmd.rd_status = sdoc_pkg::STATUS_ABORT;
    end else begin
      cmd.wr_status = ((b0 & sdoc_pkg::CS_TOP_MASK) != sdoc_pkg::CS_DOWNLOAD_RSP)
                      ? sdoc_pkg::STATUS_UNEXPECTED : sdoc_pkg::STATUS_OK;
      if ((b0 & sdoc_pkg::CS_TOP_MASK) != sdoc_pkg::CS_UPLOAD_RSP) begin
        cmd.rd_status = sdoc_pkg::STATUS_UNEXPECTED;
      end else if (!b0[1]) begin
        cmd.rd_status = sdoc_pkg::STATUS_SEGMENTED;
      end else begin
        cmd.rd_status = sdoc_pkg::STATUS_OK;
      end
    end

    unique case (func)
      sdoc_pkg::FUNC_UPLOAD:   cmd.frame = addr_bytes | {56'd0, sdoc_pkg::CS_UPLOAD_REQ};
      sdoc_pkg::FUNC_DOWNLOAD: cmd.frame = addr_bytes | {wr_masked, 24'd0, wr_cs};
      default:                 cmd.frame = rx_data;
    endcase
  end

endmodule

@@ rtl/sdoc_queue.sv @@
// ---------------------------------------------------------------------------
// sdoc_queue: command queue
// Short FIFO of decoded items between the decode front and the engine.
// ---------------------------------------------------------------------------
module sdoc_queue #(
  parameter int DEPTH = sdoc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sdoc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sdoc_pkg::cmd_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdoc_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/sdoc_back.sv @@
// ---------------------------------------------------------------------------
// sdoc_back: transfer engine
// Holds the pending transfer, matches responses, counts timeout ticks and
// drives the output register.
// ---------------------------------------------------------------------------
module sdoc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    timeout_ticks,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sdoc_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output sdoc_pkg::res_t result
);

  logic        busy;
  logic        pending_write;
  logic [6:0]  pending_node;
  logic [15:0] elapsed_ticks;

  logic        busy_next;
  logic        pending_write_next;
  logic [6:0]  pending_node_next;
  logic [15:0] elapsed_ticks_next;
  logic [15:0] ticks_inc;
  logic        rx_match;
  logic [2:0]  rx_status;
  logic        has_res;
  sdoc_pkg::res_t res;
  logic        pop;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign ticks_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign rx_match  = busy && cmd.dlc_ok
                     && (cmd.rx_id == (sdoc_pkg::SDO_RX_BASE + {4'd0, pending_node}));
  assign rx_status = pending_write ? cmd.wr_status : cmd.rd_status;

  always_comb begin
    busy_next          = busy;
    pending_write_next = pending_write;
    pending_node_next  = pending_node;
    elapsed_ticks_next = elapsed_ticks;
    has_res            = 1'b0;
    res                = '0;
    res.kind           = sdoc_pkg::KIND_DONE;

    unique case (cmd.op)
      sdoc_pkg::FUNC_UPLOAD, sdoc_pkg::FUNC_DOWNLOAD: begin
        has_res = 1'b1;
        if (busy) begin
          res.status = sdoc_pkg::STATUS_BUSY;
        end else if ((cmd.op == sdoc_pkg::FUNC_DOWNLOAD) && cmd.bad_len) begin
          res.status = sdoc_pkg::STATUS_BAD_LEN;
        end else begin
          res.kind           = sdoc_pkg::KIND_FRAME;
          res.tx_can_id      = sdoc_pkg::SDO_TX_BASE + {4'd0, cmd.node};
          res.tx_dlc         = sdoc_pkg::FRAME_DLC;
          res.tx_data        = cmd.frame;
          busy_next          = 1'b1;
          pending_write_next = (cmd.op == sdoc_pkg::FUNC_DOWNLOAD);
          pending_node_next  = cmd.node;
          elapsed_ticks_next = '0;
        end
      end
      sdoc_pkg::FUNC_RX_FRAME: begin
        if (rx_match) begin
          has_res    = 1'b1;
          busy_next  = 1'b0;
          res.status = rx_status;
          if (rx_status == sdoc_pkg::STATUS_ABORT) begin
            res.abort_code = cmd.frame[63:32];
          end
          if (!pending_write && (rx_status == sdoc_pkg::STATUS_OK)) begin
            res.read_data = cmd.rd_data;
            res.read_len  = cmd.rd_len;
          end
        end
      end
      default: begin
        // one tick: count only while a transfer is pending
        if (busy) begin
          elapsed_ticks_next = ticks_inc;
          if (ticks_inc >= timeout_ticks) begin
            has_res    = 1'b1;
            busy_next  = 1'b0;
            res.status = sdoc_pkg::STATUS_TIMEOUT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pending_write <= 1'b0;
      pending_node  <= '0;
      elapsed_ticks <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        busy          <= busy_next;
        pending_write <= pending_write_next;
        pending_node  <= pending_node_next;
        elapsed_ticks <= elapsed_ticks_next;
        out_valid     <= has_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  a_frame_starts_transfer: assert property (@(posedge clk) disable iff (rst)
    pop && has_res && (res.kind == sdoc_pkg::KIND_FRAME) |=> busy)
    else $error("transfer not pending after request frame");

  a_done_has_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.kind == sdoc_pkg::KIND_DONE)
      |-> (result.tx_data == '0) && (result.tx_can_id == '0) && (result.tx_dlc == '0))
    else $error("completion carries frame fields");

  a_abort_code_only_on_abort: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.status != sdoc_pkg::STATUS_ABORT) |-> (result.abort_code == '0))
    else $error("abort code without abort status");

  a_read_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.read_len <= 3'd4))
    else $error("read length out of range");

  a_no_busy_reply_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop && !busy |-> !(has_res && (res.status == sdoc_pkg::STATUS_BUSY)
                       && (res.kind == sdoc_pkg::KIND_DONE)))
    else $error("busy reply with no transfer pending");
`endif

endmodule
